@@ rtl/sthp_pkg.sv @@
package sthp_pkg;

	localparam int unsigned CmdW = 2;
	localparam int unsigned RawW = 20;
	localparam int unsigned OutW = 18;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CmdW-1:0] CMD_TEMP  = 2'd0;
	localparam logic [CmdW-1:0] CMD_PRESS = 2'd1;
	localparam logic [CmdW-1:0] CMD_HUMID = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_TEMP     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESS_LO = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_HI = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PRESS_P9 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HUMID    = 3'd4;

	localparam logic signed [31:0] TEMP_MIN   = -32'sd4000;
	localparam logic signed [31:0] TEMP_MAX   = 32'sd8500;
	localparam logic [31:0]        PRESS_MIN  = 32'd30000;
	localparam logic [31:0]        PRESS_MAX  = 32'd110000;
	localparam logic signed [31:0] HUM_CAP    = 32'sd419430400;
	localparam logic signed [31:0] HUM_MAX    = 32'sd102400;

	// signed divide by 2**k, truncating toward zero
	function automatic logic signed [31:0] sdiv(input logic signed [31:0] x,
		input int unsigned k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

@@ rtl/sthp_div.sv @@
module sthp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);
	import sthp_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring; the remainder stays below den whenever den is nonzero
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("divider done without run");

endmodule

@@ rtl/sensor_thp_compensation_top.sv @@
// Each item steps through its sequencer states from input transfer to output valid;
// pressure also waits on the serial divider unless its divisor is zero, and an unused
// command goes to ST_OUT at once. A result waits there while the last awaits m_tready.
// Throughput: one item at a time; the next input is taken once the sequencer is idle.
// The sequencer time-shares one 32x32 multiplier and drives the bit-serial divider.
// Reset (arst_n low, asynchronous): calibration and fine temperature cleared, idle.
module sensor_thp_compensation_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // [19:0] raw_reading
	input  logic [sthp_pkg::CmdW-1:0]     s_tuser,  // [1:0] cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,  // [17:0] compensated_value
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sthp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sthp_pkg::CfgDataW-1:0] cfg_data
);
	import sthp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
		ST_P10, ST_P11, ST_P12, ST_PDIV, ST_P14, ST_P15, ST_P16, ST_P17, ST_P18,
		ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8, ST_H9, ST_H10,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [47:0] tcal_q;
	logic [63:0] pcal_lo_q, pcal_hi_q, hcal_q;
	logic [15:0] p9_q;
	logic signed [31:0] ft_q;
	logic signed [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] p_q;
	logic [RawW-1:0] raw_q;
	logic hi_q;
	logic [OutW-1:0] res_q;
	logic m_tvalid_q;
	logic [OutW-1:0] m_data_q;

	logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [31:0] h1, h2, h3, h4, h5, h6;
	logic signed [31:0] mul_a, mul_b, prod, tmp, hum;
	logic signed [31:0] adc;
	logic div_start, div_done;
	logic [31:0] div_num, div_quo;

	assign t1 = {16'd0, tcal_q[15:0]};
	assign t2 = {{16{tcal_q[31]}}, tcal_q[31:16]};
	assign t3 = {{16{tcal_q[47]}}, tcal_q[47:32]};
	assign p1 = {16'd0, pcal_lo_q[15:0]};
	assign p2 = {{16{pcal_lo_q[31]}}, pcal_lo_q[31:16]};
	assign p3 = {{16{pcal_lo_q[47]}}, pcal_lo_q[47:32]};
	assign p4 = {{16{pcal_lo_q[63]}}, pcal_lo_q[63:48]};
	assign p5 = {{16{pcal_hi_q[15]}}, pcal_hi_q[15:0]};
	assign p6 = {{16{pcal_hi_q[31]}}, pcal_hi_q[31:16]};
	assign p7 = {{16{pcal_hi_q[47]}}, pcal_hi_q[47:32]};
	assign p8 = {{16{pcal_hi_q[63]}}, pcal_hi_q[63:48]};
	assign p9 = {{16{p9_q[15]}}, p9_q};
	assign h1 = {24'd0, hcal_q[7:0]};
	assign h2 = {{16{hcal_q[23]}}, hcal_q[23:8]};
	assign h3 = {24'd0, hcal_q[31:24]};
	assign h4 = {{20{hcal_q[43]}}, hcal_q[43:32]};
	assign h5 = {{20{hcal_q[55]}}, hcal_q[55:44]};
	assign h6 = {{24{hcal_q[63]}}, hcal_q[63:56]};
	assign adc = {12'd0, raw_q};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_T1:  begin mul_a = a_q; mul_b = t2; end
			ST_T2:  begin mul_a = b_q; mul_b = b_q; end
			ST_T3:  begin mul_a = b_q; mul_b = t3; end
			ST_T5:  begin mul_a = ft_q; mul_b = 32'sd5; end
			ST_P1:  begin mul_a = sdiv(a_q, 2); mul_b = sdiv(a_q, 2); end
			ST_P2:  begin mul_a = sdiv(c_q, 11); mul_b = p6; end
			ST_P3:  begin mul_a = a_q; mul_b = p5; end
			ST_P6:  begin mul_a = p3; mul_b = sdiv(c_q, 13); end
			ST_P7:  begin mul_a = p2; mul_b = a_q; end
			ST_P9:  begin mul_a = a_q + 32'sd32768; mul_b = p1; end
			ST_P11: begin mul_a = p_q; mul_b = 32'sd3125; end
			ST_P14: begin mul_a = {3'd0, p_q[31:3]}; mul_b = {3'd0, p_q[31:3]}; end
			ST_P15: begin mul_a = p9; mul_b = {13'd0, c_q[31:13]}; end
			ST_P16: begin mul_a = {2'd0, p_q[31:2]}; mul_b = p8; end
			ST_H1:  begin mul_a = h5; mul_b = a_q; end
			ST_H3:  begin mul_a = a_q; mul_b = h6; end
			ST_H4:  begin mul_a = a_q; mul_b = h3; end
			ST_H6:  begin mul_a = b_q; mul_b = c_q; end
			ST_H7:  begin mul_a = d_q; mul_b = h2; end
			ST_H8:  begin mul_a = e_q; mul_b = b_q; end
			ST_H9:  begin mul_a = sdiv(c_q, 15); mul_b = sdiv(c_q, 15); end
			ST_H10: begin mul_a = d_q; mul_b = h1; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// every formula wraps at 32 bits, so only the low word of the product is kept
	assign prod = mul_a * mul_b;

	always_comb begin
		tmp = sdiv(prod + 32'sd128, 8);
		hum = c_q - sdiv(prod, 4);
		if (hum < 0)
			hum = '0;
		if (hum > HUM_CAP)
			hum = HUM_CAP;
		hum = hum >>> 12;
		if (hum > HUM_MAX)
			hum = HUM_MAX;
	end

	assign div_start = (state_q == ST_P12);
	assign div_num = p_q[31] ? p_q : {p_q[30:0], 1'b0};

	sthp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (a_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q    <= '0;
			pcal_lo_q <= '0;
			pcal_hi_q <= '0;
			p9_q      <= '0;
			hcal_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMP:     tcal_q    <= cfg_data[47:0];
				REG_PRESS_LO: pcal_lo_q <= cfg_data;
				REG_PRESS_HI: pcal_hi_q <= cfg_data;
				REG_PRESS_P9: p9_q      <= cfg_data[15:0];
				REG_HUMID:    hcal_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ft_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
			res_q      <= '0;
			raw_q      <= '0;
			hi_q       <= 1'b0;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			d_q        <= '0;
			e_q        <= '0;
			p_q        <= '0;
		end else begin
			// drop valid after the transfer unless a new result replaces it
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					raw_q <= s_tdata[RawW-1:0];
					unique case (s_tuser)
						CMD_TEMP:  state_q <= ST_T0;
						CMD_PRESS: state_q <= ST_P0;
						CMD_HUMID: state_q <= ST_H0;
						default: begin
							res_q   <= '0;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_T0: begin
					a_q <= {15'd0, adc[19:3]} - (t1 <<< 1);
					b_q <= {16'd0, adc[19:4]} - t1;
					state_q <= ST_T1;
				end
				ST_T1: begin a_q <= sdiv(prod, 11); state_q <= ST_T2; end
				ST_T2: begin b_q <= sdiv(prod, 12); state_q <= ST_T3; end
				ST_T3: begin b_q <= sdiv(prod, 14); state_q <= ST_T4; end
				ST_T4: begin ft_q <= a_q + b_q; state_q <= ST_T5; end
				ST_T5: begin
					if (tmp < TEMP_MIN)
						res_q <= TEMP_MIN[OutW-1:0];
					else if (tmp > TEMP_MAX)
						res_q <= TEMP_MAX[OutW-1:0];
					else
						res_q <= tmp[OutW-1:0];
					state_q <= ST_OUT;
				end
				ST_P0: begin a_q <= sdiv(ft_q, 1) - 32'sd64000; state_q <= ST_P1; end
				ST_P1: begin c_q <= prod; state_q <= ST_P2; end
				ST_P2: begin b_q <= prod; state_q <= ST_P3; end
				ST_P3: begin d_q <= prod; state_q <= ST_P4; end
				ST_P4: begin b_q <= b_q + (d_q <<< 1); state_q <= ST_P5; end
				ST_P5: begin b_q <= sdiv(b_q, 2) + (p4 <<< 16); state_q <= ST_P6; end
				ST_P6: begin e_q <= sdiv(prod, 3); state_q <= ST_P7; end
				ST_P7: begin d_q <= sdiv(prod, 1); state_q <= ST_P8; end
				ST_P8: begin a_q <= sdiv(e_q + d_q, 18); state_q <= ST_P9; end
				ST_P9: begin a_q <= sdiv(prod, 15); state_q <= ST_P10; end
				ST_P10: begin
					if (a_q == 0) begin
						res_q   <= PRESS_MIN[OutW-1:0];
						state_q <= ST_OUT;
					end else begin
						p_q     <= 32'd1048576 - {12'd0, raw_q} - sdiv(b_q, 12);
						state_q <= ST_P11;
					end
				end
				ST_P11: begin p_q <= prod; state_q <= ST_P12; end
				ST_P12: begin hi_q <= p_q[31]; state_q <= ST_PDIV; end
				ST_PDIV: if (div_done) begin
					p_q     <= hi_q ? {div_quo[30:0], 1'b0} : div_quo;
					state_q <= ST_P14;
				end
				ST_P14: begin c_q <= prod; state_q <= ST_P15; end
				ST_P15: begin a_q <= sdiv(prod, 12); state_q <= ST_P16; end
				ST_P16: begin b_q <= sdiv(prod, 13); state_q <= ST_P17; end
				ST_P17: begin c_q <= sdiv(a_q + b_q + p7, 4); state_q <= ST_P18; end
				ST_P18: begin
					p_q <= p_q + c_q;
					if (p_q + c_q < PRESS_MIN)
						res_q <= PRESS_MIN[OutW-1:0];
					else if (p_q + c_q > PRESS_MAX)
						res_q <= PRESS_MAX[OutW-1:0];
					else
						res_q <= p_q[OutW-1:0] + c_q[OutW-1:0];
					state_q <= ST_OUT;
				end
				ST_H0: begin a_q <= ft_q - 32'sd76800; state_q <= ST_H1; end
				ST_H1: begin
					d_q <= prod;
					b_q <= (adc <<< 14) - (h4 <<< 20);
					state_q <= ST_H2;
				end
				ST_H2: begin e_q <= sdiv(b_q - d_q + 32'sd16384, 15); state_q <= ST_H3; end
				ST_H3: begin b_q <= sdiv(prod, 10); state_q <= ST_H4; end
				ST_H4: begin c_q <= sdiv(prod, 11); state_q <= ST_H5; end
				ST_H5: begin c_q <= c_q + 32'sd32768; state_q <= ST_H6; end
				ST_H6: begin d_q <= sdiv(prod, 10) + 32'sd2097152; state_q <= ST_H7; end
				ST_H7: begin b_q <= sdiv(prod + 32'sd8192, 14); state_q <= ST_H8; end
				ST_H8: begin c_q <= prod; state_q <= ST_H9; end
				ST_H9: begin d_q <= sdiv(prod, 7); state_q <= ST_H10; end
				ST_H10: begin res_q <= hum[OutW-1:0]; state_q <= ST_OUT; end
				ST_OUT: if (!m_tvalid_q || m_tready) begin
					m_data_q   <= res_q;
					m_tvalid_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(24-OutW){1'b0}}, m_data_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		(ft_q != $past(ft_q)) |-> ($past(state_q) == ST_T4))
		else $error("fine temperature written outside temperature path");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_PDIV))
		else $error("divider result with no pressure item waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("accepted item did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result shown without finishing an item");

endmodule

@@ bench/sensor_thp_compensation_top_test.sv @@
module sensor_thp_compensation_top_test;
	import sthp_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;
	localparam logic [CmdW-1:0]    CMD_NONE  = 2'd3;

	typedef struct packed {
		logic [CmdW-1:0] cmd;
		logic [RawW-1:0] raw;
	} reading_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [23:0]         s_tdata;
	logic [CmdW-1:0]     s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [23:0]         m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	sensor_thp_compensation_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [47:0] temp_cal;
	logic [63:0] press_lo_cal, press_hi_cal, humid_cal;
	logic [15:0] press_p9_cal;
	int          fine_temp;

	reading_t        reading_queue[$];
	logic [OutW-1:0] expected_values[$];
	int   error_count, sent_count, result_count, cfg_count;
	int   cmd_count[4];
	bit   in_fire, out_fire, calm;
	int   send_gap, recv_stall;

	task automatic report(input string what);
		error_count++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic int temp_value(input int adc);
		int t1, t2, t3, a, b, t;
		t1 = temp_cal[15:0];
		t2 = $signed(temp_cal[31:16]);
		t3 = $signed(temp_cal[47:32]);
		a = adc / 8 - t1 * 2;
		a = (a * t2) / 2048;
		b = adc / 16 - t1;
		b = (b * b) / 4096;
		b = (b * t3) / 16384;
		fine_temp = a + b;
		t = (fine_temp * 5 + 128) / 256;
		if (t < TEMP_MIN) t = TEMP_MIN;
		else if (t > TEMP_MAX) t = TEMP_MAX;
		return t;
	endfunction

	function automatic int press_value(input int adc);
		int p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, c, d, q, sq;
		int unsigned p, divisor, pq;
		p1 = press_lo_cal[15:0];
		p2 = $signed(press_lo_cal[31:16]);
		p3 = $signed(press_lo_cal[47:32]);
		p4 = $signed(press_lo_cal[63:48]);
		p5 = $signed(press_hi_cal[15:0]);
		p6 = $signed(press_hi_cal[31:16]);
		p7 = $signed(press_hi_cal[47:32]);
		p8 = $signed(press_hi_cal[63:48]);
		p9 = $signed(press_p9_cal);
		a = fine_temp / 2 - 64000;
		q = a / 4;
		sq = q * q;
		b = (sq / 2048) * p6;
		b = b + (a * p5) * 2;
		b = b / 4 + p4 * 65536;
		c = (p3 * (sq / 8192)) / 8;
		d = (p2 * a) / 2;
		a = (c + d) / 262144;
		a = ((32768 + a) * p1) / 32768;
		if (a == 0) return PRESS_MIN;
		divisor = a;
		p = 32'd1048576 - adc;
		p = (p - $unsigned(b / 4096)) * 32'd3125;
		if (p < 32'h8000_0000) p = (p << 1) / divisor;
		else p = (p / divisor) * 32'd2;
		pq = ((p >> 3) * (p >> 3)) / 32'd8192;
		a = (p9 * $signed(pq)) / 4096;
		b = ($signed(p >> 2) * p8) / 8192;
		c = (a + b + p7) / 16;
		p = p + c;
		if (p < PRESS_MIN) p = PRESS_MIN;
		else if (p > PRESS_MAX) p = PRESS_MAX;
		return p;
	endfunction

	function automatic int humid_value(input int adc);
		int h1, h2, h3, h4, h5, h6, a, b, c, d, e;
		h1 = humid_cal[7:0];
		h2 = $signed(humid_cal[23:8]);
		h3 = humid_cal[31:24];
		h4 = $signed(humid_cal[43:32]);
		h5 = $signed(humid_cal[55:44]);
		h6 = $signed(humid_cal[63:56]);
		a = fine_temp - 76800;
		b = adc * 16384;
		c = h4 * 1048576;
		d = h5 * a;
		e = (b - c - d + 16384) / 32768;
		b = (a * h6) / 1024;
		c = (a * h3) / 2048;
		d = (b * (c + 32768)) / 1024 + 2097152;
		b = (d * h2 + 8192) / 16384;
		c = e * b;
		d = ((c / 32768) * (c / 32768)) / 128;
		e = c - (d * h1) / 16;
		if (e < 0) e = 0;
		if (e > HUM_CAP) e = HUM_CAP;
		e = e / 4096;
		if (e > HUM_MAX) e = HUM_MAX;
		return e;
	endfunction

	function automatic logic [OutW-1:0] compensate(input reading_t r);
		int v;
		case (r.cmd)
			CMD_TEMP:  v = temp_value(int'(r.raw));
			CMD_PRESS: v = press_value(int'(r.raw));
			CMD_HUMID: v = humid_value(int'(r.raw));
			default:   v = 0;
		endcase
		return v[OutW-1:0];
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// monitor: record transfers, predict on input, check on output
	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		out_fire <= m_tvalid && m_tready;
		if (arst_n && s_tvalid && s_tready) begin
			expected_values.push_back(compensate('{cmd: s_tuser, raw: s_tdata[RawW-1:0]}));
			sent_count++;
			cmd_count[s_tuser]++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			result_count++;
			if (expected_values.size() == 0)
				report($sformatf("unexpected result %0h", m_tdata[OutW-1:0]));
			else begin
				logic [OutW-1:0] want;
				want = expected_values.pop_front();
				if (m_tdata[OutW-1:0] !== want)
					report($sformatf("compensated_value %0h, want %0h",
						m_tdata[OutW-1:0], want));
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_fire)) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (reading_queue.size() != 0) begin
				reading_t r;
				r = reading_queue.pop_front();
				s_tdata <= {4'b0, r.raw};
				s_tuser <= r.cmd;
				s_tvalid <= 1'b1;
				send_gap <= calm ? 0 : $urandom_range(0, 8);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// output stalls
	always @(negedge clk) begin
		if (arst_n) begin
			int st;
			st = out_fire ? (calm ? 0 : $urandom_range(0, 8)) : recv_stall;
			m_tready <= (st == 0);
			recv_stall <= (st > 0) ? st - 1 : 0;
		end
	end

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEMP:     temp_cal = value[47:0];
			REG_PRESS_LO: press_lo_cal = value;
			REG_PRESS_HI: press_hi_cal = value;
			REG_PRESS_P9: press_p9_cal = value[15:0];
			REG_HUMID:    humid_cal = value;
			default: ;
		endcase
		cfg_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off until everything sent has come back, then let the pipe empty
	task automatic drain();
		while (reading_queue.size() != 0 || s_tvalid || expected_values.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic push(input logic [CmdW-1:0] c, input logic [RawW-1:0] r);
		reading_queue.push_back('{cmd: c, raw: r});
	endtask

	function automatic logic [63:0] jitter(input logic [63:0] w, input int bits);
		return w ^ {16'($urandom_range(0, (1 << bits) - 1)),
			16'($urandom_range(0, (1 << bits) - 1)),
			16'($urandom_range(0, (1 << bits) - 1)),
			16'($urandom_range(0, (1 << bits) - 1))};
	endfunction

	task automatic load_cal(input int kind);
		logic [63:0] t, pl, ph, h;
		logic [15:0] p9;
		t  = {16'h0, 16'hFC18, 16'd26435, 16'd27504};
		pl = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
		ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
		p9 = 16'd6000;
		h  = {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75};
		case (kind)
			1: begin
				t = jitter(t, 6); pl = jitter(pl, 6); ph = jitter(ph, 6);
				p9 = p9 ^ 16'($urandom_range(0, 63)); h = jitter(h, 4);
			end
			2: begin
				t = {$urandom, $urandom}; pl = {$urandom, $urandom};
				ph = {$urandom, $urandom}; p9 = 16'($urandom); h = {$urandom, $urandom};
			end
			3: begin
				t = '1; pl = '1; ph = '1; p9 = '1; h = '1;
			end
			4: begin
				t = {4{16'h8000}}; pl = {4{16'h8000}}; ph = {4{16'h8000}};
				p9 = 16'h8000; h = 64'h8080_0800_8080_0080;
			end
			5: begin
				t = {4{16'h7FFF}}; pl = {4{16'h7FFF}}; ph = {4{16'h7FFF}};
				p9 = 16'h7FFF; h = 64'h7F7F_F7FF_FF7F_FFFF;
			end
			6: begin
				t = '0; pl = '0; ph = '0; p9 = '0; h = '0;
			end
			default: ;
		endcase
		cfg_write(REG_TEMP, t);
		cfg_write(REG_PRESS_LO, pl);
		cfg_write(REG_PRESS_HI, ph);
		cfg_write(REG_PRESS_P9, {48'b0, p9});
		cfg_write(REG_HUMID, h);
	endtask

	// mostly a temperature reading followed by a few pressure or humidity readings
	task automatic add_readings(input int n);
		int k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 3) != 0) begin
				push(CMD_TEMP, 20'(450000 + $urandom_range(0, 150000)));
				k++;
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1))
						push(CMD_PRESS, 20'(330000 + $urandom_range(0, 150000)));
					else if ($urandom_range(0, 5) != 0)
						push(CMD_HUMID, 20'($urandom_range(15000, 50000)));
					else
						push(CMD_HUMID, 20'($urandom));
					k++;
				end
			end else begin
				push(2'($urandom_range(0, 3)), 20'($urandom));
				k++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = CMD_TEMP;
		m_tready = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_TEMP; cfg_data = '0;
		temp_cal = '0; press_lo_cal = '0; press_hi_cal = '0; press_p9_cal = '0;
		humid_cal = '0; fine_temp = 0;
		in_fire = 1'b0; out_fire = 1'b0; calm = 1'b0; send_gap = 0; recv_stall = 0;
		error_count = 0; sent_count = 0; result_count = 0; cfg_count = 0;
		cmd_count = '{default: 0};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// uncalibrated: pressure and humidity before any temperature, zero divisor
		push(CMD_PRESS, 20'd415148);
		push(CMD_HUMID, 20'd30000);
		push(CMD_NONE, 20'hFFFFF);
		push(CMD_TEMP, 20'd0);
		push(CMD_PRESS, 20'hFFFFF);
		drain();

		load_cal(0);
		push(CMD_TEMP, 20'd519888);
		push(CMD_PRESS, 20'd415148);
		push(CMD_HUMID, 20'd30000);
		push(CMD_HUMID, 20'hFFFFF);
		push(CMD_HUMID, 20'd0);
		push(CMD_PRESS, 20'd0);
		push(CMD_PRESS, 20'hFFFFF);
		push(CMD_NONE, 20'd0);
		push(CMD_TEMP, 20'hFFFFF);
		push(CMD_PRESS, 20'd415148);
		push(CMD_HUMID, 20'hFFFFF);
		push(CMD_TEMP, 20'd0);
		push(CMD_HUMID, 20'd65535);
		push(CMD_PRESS, 20'd200000);
		push(CMD_TEMP, 20'd300000);
		push(CMD_TEMP, 20'd700000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3 || ph == 6);
			load_cal(ph == 7 ? 1 : ph);
			if (ph == 2)
				cfg_write(REG_SPARE, {$urandom, $urandom});
			add_readings(ph == 0 || ph == 1 || ph == 7 ? 400 : 180);
			drain();
		end

		$display("Sent %0d readings (temp %0d, press %0d, humid %0d, unused %0d),",
			sent_count, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
		$display("checked %0d results over %0d calibration writes", result_count, cfg_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sthp_pkg.sv
rtl/sthp_div.sv
rtl/sensor_thp_compensation_top.sv
bench/sensor_thp_compensation_top_test.sv
